@@ design/kcore_decomposition_engine_macros.svh @@
// Assertion macros for the k-core decomposition engine.
`ifndef KCORE_DECOMPOSITION_ENGINE_MACROS_SVH
`define KCORE_DECOMPOSITION_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define KCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/kcd_pkg.sv @@
// Package: item types, codes and size defaults of the k-core engine.
`timescale 1ns / 1ps

package kcd_pkg;

	localparam int CMD_W  = 2;
	localparam int VTX_W  = 10;
	localparam int CORE_W = 13;
	localparam int STAT_W = 3;
	localparam int CFG_W  = 11;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int MAX_EDGES_DEF    = 8192;

	localparam logic [CORE_W-1:0] CORE_SAT = 13'd8191;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_RUN   = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_code_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_RANGE  = 3'd2,
		ST_ORDER  = 3'd3,
		ST_NOTRUN = 3'd4
	} status_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [VTX_W-1:0] vertex;
		logic [VTX_W-1:0] neighbour;
	} cmd_item_t;

	typedef struct packed {
		logic [CORE_W-1:0] core_number;
		logic [CORE_W-1:0] max_core;
		logic [STAT_W-1:0] status;
	} result_item_t;

endpackage

@@ design/kcore_decomposition_engine.sv @@
// Top level: k-core decomposition engine with edge store and peeling sequencer.
`timescale 1ns / 1ps
`include "kcore_decomposition_engine_macros.svh"

// A load whose vertex equals the last loaded one is stored directly; a load that moves
// to a higher vertex first writes the offsets of the skipped vertices and of its own
// vertex, one per cycle. A run does degree counting, a bin sort by degree and peeling
// over every stored edge, then finds the largest core; all state sits in memories
// with one registered read port each. busy is high while an item is in progress.
// Each item other than command 3 gives one result on done for one cycle; the
// receiver cannot stall it.
module kcore_decomposition_engine #(
	parameter int MAX_VERTICES = kcd_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = kcd_pkg::MAX_EDGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  kcd_pkg::cmd_item_t          cmd,
	output logic                        done,
	output kcd_pkg::result_item_t       result,
	input  logic                        cfg_we,
	input  logic [kcd_pkg::CFG_W-1:0]   cfg_wdata
);
	import kcd_pkg::*;

	localparam int VIW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW   = $clog2(MAX_VERTICES + 1);
	localparam int EIW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW  = $clog2(MAX_EDGES + 1);
	localparam int BW   = (ECW > CW) ? ECW : CW;
	localparam int CMPW = (CW > VTX_W) ? CW : VTX_W;
	localparam int CFW  = (CW > CFG_W) ? CW : CFG_W;
	localparam int DGW  = (ECW > CORE_W) ? ECW : CORE_W;
	localparam int PCW  = (BW > CMPW) ? BW : CMPW;

	typedef enum logic [4:0] {
		S_IDLE, S_FILL, S_D_HI, S_D_HIW, S_D_EDGE, S_D_EDGEW, S_CLR,
		S_H_RD, S_H_BRD, S_H_WR, S_PFX_RD, S_PFX_WR, S_PL_RD, S_PL_BRD, S_PL_WR,
		S_SH, S_SH_WR, S_P_I, S_P_V, S_P_LO, S_P_HI, S_P_E, S_P_U, S_P_DU,
		S_P_PW, S_P_W, S_P_SW2, S_PK, S_PK_W, S_Q_W
	} state_t;

	function automatic logic [CORE_W-1:0] sat_core(input logic [ECW-1:0] c);
		sat_core = (DGW'(c) > DGW'(CORE_SAT)) ? CORE_SAT : CORE_W'(c);
	endfunction

	// memories
	logic [VTX_W-1:0] adj_mem  [MAX_EDGES];
	logic [ECW-1:0]   eoff_mem [MAX_VERTICES+1];
	logic [ECW-1:0]   deg_mem  [MAX_VERTICES];
	logic [VIW-1:0]   pos_mem  [MAX_VERTICES];
	logic [VIW-1:0]   vap_mem  [MAX_VERTICES];
	logic [BW-1:0]    bin_mem  [MAX_EDGES+1];

	logic             adj_we, eoff_we, deg_we, pos_we, vap_we, bin_we;
	logic [EIW-1:0]   adj_wa, adj_ra;
	logic [VTX_W-1:0] adj_wd, adj_rd;
	logic [CW-1:0]    eoff_wa, eoff_ra;
	logic [ECW-1:0]   eoff_wd, eoff_rd;
	logic [VIW-1:0]   deg_wa, deg_ra, pos_wa, pos_ra, vap_wa, vap_ra;
	logic [ECW-1:0]   deg_wd, deg_rd;
	logic [VIW-1:0]   pos_wd, pos_rd, vap_wd, vap_rd;
	logic [ECW-1:0]   bin_wa, bin_ra;
	logic [BW-1:0]    bin_wd, bin_rd;

	always_ff @(posedge clk) begin
		if (adj_we) adj_mem[adj_wa] <= adj_wd;
		adj_rd <= adj_mem[adj_ra];
	end
	always_ff @(posedge clk) begin
		if (eoff_we) eoff_mem[eoff_wa] <= eoff_wd;
		eoff_rd <= eoff_mem[eoff_ra];
	end
	always_ff @(posedge clk) begin
		if (deg_we) deg_mem[deg_wa] <= deg_wd;
		deg_rd <= deg_mem[deg_ra];
	end
	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[pos_wa] <= pos_wd;
		pos_rd <= pos_mem[pos_ra];
	end
	always_ff @(posedge clk) begin
		if (vap_we) vap_mem[vap_wa] <= vap_wd;
		vap_rd <= vap_mem[vap_ra];
	end
	always_ff @(posedge clk) begin
		if (bin_we) bin_mem[bin_wa] <= bin_wd;
		bin_rd <= bin_mem[bin_ra];
	end

	// control and datapath registers
	state_t           state_q;
	logic [CW-1:0]    vcount_q;
	logic [ECW-1:0]   edges_q;
	logic [VIW-1:0]   last_q;
	logic             computed_q;
	logic [ECW-1:0]   peak_q;
	logic             done_q;
	result_item_t     result_q;
	logic [VIW-1:0]   tgt_q;
	logic [VTX_W-1:0] nb_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    v_q;
	logic [VIW-1:0]   pv_q;
	logic [ECW-1:0]   e_q, hi_q, cnt_q, md_q, d_q, dcur_q, dv_q, du_q;
	logic [BW-1:0]    acc_q, pwraw_q;
	logic [VIW-1:0]   u_q, pu_q, pw_q, w_q;

	// offset of a vertex: zero for vertex 0, stored value up to the last loaded
	// vertex, running edge count above it
	logic             emem_s1, ezero_s1;
	logic [ECW-1:0]   off_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emem_s1  <= 1'b0;
			ezero_s1 <= 1'b1;
		end else begin
			emem_s1  <= (eoff_ra != '0) && (eoff_ra <= CW'(last_q));
			ezero_s1 <= (eoff_ra == '0);
		end
	end
	assign off_val = emem_s1 ? eoff_rd : (ezero_s1 ? '0 : edges_q);

	// decode of the incoming item
	logic accept, v_ok, nb_ok, ld_ok, ld_adv, v_last;
	logic [ECW-1:0] pk_new;
	logic [VIW-1:0] pw_c;
	logic           adj_in;

	assign accept = start && (state_q == S_IDLE);
	assign v_ok   = CMPW'(cmd.vertex) < CMPW'(vcount_q);
	assign nb_ok  = CMPW'(cmd.neighbour) < CMPW'(vcount_q);
	assign ld_ok  = v_ok && nb_ok && (VIW'(cmd.vertex) >= last_q) &&
		(edges_q < ECW'(MAX_EDGES));
	assign ld_adv = VIW'(cmd.vertex) > last_q;
	assign v_last = (v_q + 1'b1) == vcount_q;
	assign pk_new = (deg_rd > peak_q) ? deg_rd : peak_q;
	assign pw_c   = (PCW'(bin_rd) >= PCW'(vcount_q)) ? VIW'(vcount_q - 1'b1) : VIW'(bin_rd);
	assign adj_in = CMPW'(adj_rd) < CMPW'(vcount_q);

	always_comb begin
		adj_we = 1'b0; adj_wa = EIW'(edges_q); adj_wd = cmd.neighbour; adj_ra = EIW'(e_q);
		eoff_we = 1'b0; eoff_wa = fill_q; eoff_wd = edges_q; eoff_ra = '0;
		deg_we = 1'b0; deg_wa = VIW'(v_q); deg_wd = cnt_q; deg_ra = VIW'(v_q);
		pos_we = 1'b0; pos_wa = VIW'(v_q); pos_wd = VIW'(bin_rd); pos_ra = u_q;
		vap_we = 1'b0; vap_wa = VIW'(bin_rd); vap_wd = VIW'(v_q); vap_ra = VIW'(v_q);
		bin_we = 1'b0; bin_wa = d_q; bin_wd = '0; bin_ra = d_q;
		case (state_q)
			S_IDLE: begin
				if (accept && cmd.command == CMD_LOAD && ld_ok && !ld_adv) begin
					adj_we = 1'b1;
				end
				deg_ra = VIW'(cmd.vertex);
			end
			S_FILL: begin
				eoff_we = 1'b1;
				adj_wd  = nb_q;
				if (fill_q == CW'(tgt_q)) begin
					adj_we = 1'b1;
				end
			end
			S_D_HI:    eoff_ra = v_q + 1'b1;
			S_D_EDGE: begin
				if (e_q >= hi_q) begin
					deg_we = 1'b1;
				end
			end
			S_CLR:     bin_we = 1'b1;
			S_H_BRD:   bin_ra = deg_rd;
			S_H_WR: begin
				bin_we = 1'b1; bin_wa = dcur_q; bin_wd = bin_rd + 1'b1;
			end
			S_PFX_WR: begin
				bin_we = 1'b1; bin_wd = acc_q;
			end
			S_PL_BRD:  bin_ra = deg_rd;
			S_PL_WR: begin
				pos_we = 1'b1; vap_we = 1'b1;
				bin_we = 1'b1; bin_wa = dcur_q; bin_wd = bin_rd + 1'b1;
			end
			S_SH: begin
				bin_ra = d_q - 1'b1;
				if (d_q == '0) begin
					bin_we = 1'b1;
				end
			end
			S_SH_WR: begin
				bin_we = 1'b1; bin_wd = bin_rd;
			end
			S_P_V: begin
				deg_ra  = vap_rd;
				eoff_ra = CW'(vap_rd);
			end
			S_P_LO:    eoff_ra = CW'(pv_q) + 1'b1;
			S_P_U:     deg_ra = VIW'(adj_rd);
			S_P_DU:    bin_ra = deg_rd;
			S_P_PW:    vap_ra = pw_c;
			S_P_W: begin
				if (u_q != vap_rd) begin
					pos_we = 1'b1; pos_wa = u_q; pos_wd = pw_q;
					vap_we = 1'b1; vap_wa = pu_q; vap_wd = vap_rd;
				end
				bin_we = 1'b1; bin_wa = du_q; bin_wd = pwraw_q + 1'b1;
				deg_we = 1'b1; deg_wa = u_q; deg_wd = du_q - 1'b1;
			end
			S_P_SW2: begin
				pos_we = 1'b1; pos_wa = w_q; pos_wd = pu_q;
				vap_we = 1'b1; vap_wa = pw_q; vap_wd = u_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			vcount_q   <= '0;
			edges_q    <= '0;
			last_q     <= '0;
			computed_q <= 1'b0;
			peak_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						vcount_q <= (CFW'(cfg_wdata) > CFW'(MAX_VERTICES)) ?
							CW'(MAX_VERTICES) : CW'(cfg_wdata);
						computed_q <= 1'b0;
					end
					if (accept) begin
						result_q.core_number <= '0;
						result_q.max_core    <= computed_q ? sat_core(peak_q) : '0;
						case (cmd.command)
							CMD_LOAD: begin
								if (!v_ok || !nb_ok) begin
									done_q <= 1'b1; result_q.status <= ST_RANGE;
								end else if (VIW'(cmd.vertex) < last_q) begin
									done_q <= 1'b1; result_q.status <= ST_ORDER;
								end else if (edges_q >= ECW'(MAX_EDGES)) begin
									done_q <= 1'b1; result_q.status <= ST_FULL;
								end else if (ld_adv) begin
									fill_q  <= CW'(last_q) + 1'b1;
									tgt_q   <= VIW'(cmd.vertex);
									nb_q    <= cmd.neighbour;
									state_q <= S_FILL;
								end else begin
									edges_q    <= edges_q + 1'b1;
									computed_q <= 1'b0;
									done_q     <= 1'b1;
									result_q.max_core <= '0;
									result_q.status   <= ST_OK;
								end
							end
							CMD_RUN: begin
								v_q    <= '0;
								e_q    <= '0;
								md_q   <= '0;
								peak_q <= '0;
								if (vcount_q == '0) begin
									computed_q <= 1'b1;
									done_q     <= 1'b1;
									result_q.max_core <= '0;
									result_q.status   <= ST_OK;
								end else begin
									state_q <= S_D_HI;
								end
							end
							CMD_QUERY: begin
								if (!computed_q) begin
									done_q <= 1'b1; result_q.status <= ST_NOTRUN;
								end else if (!v_ok) begin
									done_q <= 1'b1; result_q.status <= ST_RANGE;
								end else begin
									state_q <= S_Q_W;
								end
							end
							default: ;
						endcase
					end
				end
				S_FILL: begin
					if (fill_q == CW'(tgt_q)) begin
						edges_q    <= edges_q + 1'b1;
						last_q     <= tgt_q;
						computed_q <= 1'b0;
						done_q     <= 1'b1;
						result_q.max_core <= '0;
						result_q.status   <= ST_OK;
						state_q    <= S_IDLE;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
				S_Q_W: begin
					done_q <= 1'b1;
					result_q.core_number <= sat_core(deg_rd);
					result_q.status      <= ST_OK;
					state_q <= S_IDLE;
				end
				// degree count, low offset carried over from the previous vertex
				S_D_HI:  state_q <= S_D_HIW;
				S_D_HIW: begin
					hi_q    <= off_val;
					cnt_q   <= '0;
					state_q <= S_D_EDGE;
				end
				S_D_EDGE: begin
					if (e_q < hi_q) begin
						state_q <= S_D_EDGEW;
					end else begin
						if (cnt_q > md_q) md_q <= cnt_q;
						v_q <= v_q + 1'b1;
						if (v_last) begin
							d_q <= '0; state_q <= S_CLR;
						end else begin
							state_q <= S_D_HI;
						end
					end
				end
				S_D_EDGEW: begin
					if (adj_in) cnt_q <= cnt_q + 1'b1;
					e_q     <= e_q + 1'b1;
					state_q <= S_D_EDGE;
				end
				S_CLR: begin
					if (d_q == md_q) begin
						v_q <= '0; state_q <= S_H_RD;
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
				S_H_RD:  state_q <= S_H_BRD;
				S_H_BRD: begin
					dcur_q <= deg_rd; state_q <= S_H_WR;
				end
				S_H_WR: begin
					v_q <= v_q + 1'b1;
					if (v_last) begin
						d_q <= '0; acc_q <= '0; state_q <= S_PFX_RD;
					end else begin
						state_q <= S_H_RD;
					end
				end
				S_PFX_RD: state_q <= S_PFX_WR;
				S_PFX_WR: begin
					acc_q <= acc_q + bin_rd;
					if (d_q == md_q) begin
						v_q <= '0; state_q <= S_PL_RD;
					end else begin
						d_q <= d_q + 1'b1; state_q <= S_PFX_RD;
					end
				end
				S_PL_RD:  state_q <= S_PL_BRD;
				S_PL_BRD: begin
					dcur_q <= deg_rd; state_q <= S_PL_WR;
				end
				S_PL_WR: begin
					v_q <= v_q + 1'b1;
					if (v_last) begin
						d_q <= md_q; state_q <= S_SH;
					end else begin
						state_q <= S_PL_RD;
					end
				end
				// bin starts move up one degree
				S_SH: begin
					if (d_q == '0) begin
						v_q <= '0; state_q <= S_P_I;
					end else begin
						state_q <= S_SH_WR;
					end
				end
				S_SH_WR: begin
					d_q <= d_q - 1'b1; state_q <= S_SH;
				end
				// peeling in order of position
				S_P_I: state_q <= S_P_V;
				S_P_V: begin
					pv_q <= vap_rd; state_q <= S_P_LO;
				end
				S_P_LO: begin
					dv_q <= deg_rd; e_q <= off_val; state_q <= S_P_HI;
				end
				S_P_HI: begin
					hi_q <= off_val; state_q <= S_P_E;
				end
				S_P_E: begin
					if (e_q < hi_q) begin
						state_q <= S_P_U;
					end else begin
						v_q <= v_q + 1'b1;
						if (v_last) begin
							v_q <= '0; state_q <= S_PK;
						end else begin
							state_q <= S_P_I;
						end
					end
				end
				S_P_U: begin
					u_q <= VIW'(adj_rd);
					if (adj_in) begin
						state_q <= S_P_DU;
					end else begin
						e_q <= e_q + 1'b1; state_q <= S_P_E;
					end
				end
				S_P_DU: begin
					du_q <= deg_rd;
					if (deg_rd > dv_q) begin
						state_q <= S_P_PW;
					end else begin
						e_q <= e_q + 1'b1; state_q <= S_P_E;
					end
				end
				S_P_PW: begin
					pu_q    <= pos_rd;
					pwraw_q <= bin_rd;
					pw_q    <= pw_c;
					state_q <= S_P_W;
				end
				S_P_W: begin
					w_q <= vap_rd;
					if (u_q != vap_rd) begin
						state_q <= S_P_SW2;
					end else begin
						e_q <= e_q + 1'b1; state_q <= S_P_E;
					end
				end
				S_P_SW2: begin
					e_q <= e_q + 1'b1; state_q <= S_P_E;
				end
				S_PK:   state_q <= S_PK_W;
				S_PK_W: begin
					peak_q <= pk_new;
					v_q    <= v_q + 1'b1;
					if (v_last) begin
						computed_q <= 1'b1;
						done_q     <= 1'b1;
						result_q.core_number <= '0;
						result_q.max_core    <= sat_core(pk_new);
						result_q.status      <= ST_OK;
						state_q    <= S_IDLE;
					end else begin
						state_q <= S_PK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	`KCD_ASSERT_NEXT(a_done_has_cause, !start && !busy, !done, "result without an item")
	`KCD_ASSERT_NOW(a_notrun_zero, done && result.status == ST_NOTRUN,
		result.core_number == '0 && result.max_core == '0, "not-computed result not zero")
	`KCD_ASSERT_NOW(a_peel_in_range, state_q == S_P_PW,
		CMPW'(u_q) < CMPW'(vcount_q), "peeled neighbour beyond vertex count")
	`KCD_ASSERT_NOW(a_bin_bound, bin_we && state_q != S_IDLE, bin_wa <= md_q,
		"bin write above largest degree")

endmodule

@@ tb/sv/tb_kcore_decomposition_engine.sv @@
// Testbench for the k-core engine: random graphs, runs and queries checked against a predictor.
`timescale 1ns / 1ps

module tb_kcore_decomposition_engine;
	import kcd_pkg::*;

	class kcore_tracker;
		bit [10:0] vtx_limit;
		bit [13:0] offsets[1025];
		bit [9:0]  adj_store[8192];
		bit [13:0] n_edges;
		bit [9:0]  last_vtx;
		bit [13:0] cur_deg[1024];
		bit [9:0]  pos_of[1024];
		bit [9:0]  vtx_at[1024];
		bit [13:0] bin_lo[8193];
		bit        have_cores;
		bit [13:0] peak;
		result_item_t pending_results[$];
		int errors;

		function void write_limit(bit [10:0] val);
			vtx_limit = (val > 1024) ? 11'd1024 : val;
			have_cores = 0;
		endfunction

		function bit [12:0] sat13(bit [13:0] c);
			return (c > 14'd8191) ? CORE_SAT : c[12:0];
		endfunction

		function status_t store_edge(int v, int u);
			if (v >= vtx_limit || u >= vtx_limit) return ST_RANGE;
			if (v < last_vtx) return ST_ORDER;
			if (n_edges >= 8192) return ST_FULL;
			adj_store[n_edges] = 10'(u);
			n_edges++;
			for (int x = v + 1; x <= 1024; x++) offsets[x] = n_edges;
			last_vtx = 10'(v);
			have_cores = 0;
			return ST_OK;
		endfunction

		// bin-sort peeling; cur_deg ends up holding the core numbers
		function void peel_graph();
			int n, md, acc, num, v, u, du, pu, pw, w;
			n = vtx_limit;
			md = 0;
			acc = 0;
			for (v = 0; v < n; v++) begin
				cur_deg[v] = '0;
				for (int e = offsets[v]; e < offsets[v+1] && e < 8192; e++)
					if (adj_store[e] < n) cur_deg[v]++;
				if (cur_deg[v] > md) md = cur_deg[v];
			end
			for (int d = 0; d <= md; d++) bin_lo[d] = '0;
			for (v = 0; v < n; v++) bin_lo[cur_deg[v]]++;
			for (int d = 0; d <= md; d++) begin
				num = bin_lo[d];
				bin_lo[d] = 14'(acc);
				acc += num;
			end
			for (v = 0; v < n; v++) begin
				pu = bin_lo[cur_deg[v]];
				pos_of[v] = 10'(pu);
				vtx_at[pu] = 10'(v);
				bin_lo[cur_deg[v]]++;
			end
			for (int d = md; d > 0; d--) bin_lo[d] = bin_lo[d-1];
			bin_lo[0] = '0;
			for (int i = 0; i < n; i++) begin
				v = vtx_at[i];
				for (int e = offsets[v]; e < offsets[v+1] && e < 8192; e++) begin
					u = adj_store[e];
					if (u < n && cur_deg[u] > cur_deg[v]) begin
						du = cur_deg[u];
						pu = pos_of[u];
						pw = bin_lo[du];
						if (pw >= n) pw = n - 1;
						w = vtx_at[pw];
						if (u != w) begin
							pos_of[u] = 10'(pw);
							pos_of[w] = 10'(pu);
							vtx_at[pu] = 10'(w);
							vtx_at[pw] = 10'(u);
						end
						bin_lo[du]++;
						cur_deg[u] = 14'(du - 1);
					end
				end
			end
			peak = '0;
			for (v = 0; v < n; v++) if (cur_deg[v] > peak) peak = cur_deg[v];
			have_cores = 1;
		endfunction

		function void note_command(cmd_item_t c);
			result_item_t r;
			r = '0;
			case (cmd_code_t'(c.command))
				CMD_LOAD: r.status = store_edge(c.vertex, c.neighbour);
				CMD_RUN: begin
					peel_graph();
					r.status = ST_OK;
				end
				CMD_QUERY: begin
					if (!have_cores) r.status = ST_NOTRUN;
					else if (c.vertex >= vtx_limit) r.status = ST_RANGE;
					else begin
						r.core_number = sat13(cur_deg[c.vertex]);
						r.status = ST_OK;
					end
				end
				default: return;
			endcase
			r.max_core = have_cores ? sat13(peak) : '0;
			pending_results.push_back(r);
		endfunction

		function void check_result(result_item_t got);
			result_item_t exp;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
				return;
			end
			exp = pending_results.pop_front();
			if (got.core_number !== exp.core_number || got.max_core !== exp.max_core ||
					got.status !== exp.status) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp core %0d max %0d st %0d, got core %0d max %0d st %0d",
						exp.core_number, exp.max_core, exp.status,
						got.core_number, got.max_core, got.status);
			end
		endfunction
	endclass

	localparam longint CYCLE_LIMIT = 4000000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	cmd_item_t cmd = '0;
	logic done;
	result_item_t result;
	logic cfg_we = 0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	kcore_tracker tracker = new();
	longint cycles = 0;
	int burst_left = 0;

	kcore_decomposition_engine u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) tracker.note_command(cmd);
			if (done) tracker.check_result(result);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic idle(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic send(cmd_code_t op, int v, int u);
		if (burst_left == 0) begin
			// a short idle gap before most bursts, none before the rest
			if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		cmd <= '{command: op, vertex: v[9:0], neighbour: u[9:0]};
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		idle(1);
		while (tracker.pending_results.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		idle(4);
	endtask

	task automatic write_limit(int val);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val[CFG_W-1:0];
		tracker.write_limit(val[CFG_W-1:0]);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic query_some(int n);
		for (int i = 0; i < n; i++)
			send(CMD_QUERY, $urandom_range(0, tracker.vtx_limit), 0);
	endtask

	// add a band of vertices with clustered neighbours, plus some noise
	task automatic grow_graph(int span);
		int vc, u;
		vc = tracker.last_vtx + span;
		if (vc > 1024) vc = 1024;
		write_limit(vc);
		for (int v = tracker.last_vtx; v < vc; v++) begin
			repeat ($urandom_range(0, 7)) begin
				if ($urandom_range(0, 9) == 0) begin
					send(cmd_code_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
						$urandom_range(0, 1023));
				end else begin
					u = v + $urandom_range(0, 12) - 6;
					if (u < 0) u = 0;
					if (u >= vc) u = vc - 1;
					send(CMD_LOAD, v, u);
				end
			end
		end
		send(CMD_RUN, 0, 0);
		query_some(12);
		if ($urandom_range(0, 2) == 0) begin
			// lowered limit leaves stored neighbours outside the graph
			write_limit(vc - $urandom_range(1, 5));
			send(CMD_RUN, 0, 0);
			query_some(6);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send(CMD_QUERY, 0, 0);
		send(CMD_NONE, 1023, 1023);
		send(CMD_RUN, 0, 0);
		send(CMD_QUERY, 0, 0);
		write_limit(2047);
		write_limit(8);
		send(CMD_LOAD, 9, 0);
		send(CMD_LOAD, 0, 1023);
		send(CMD_LOAD, 2, 3);
		send(CMD_LOAD, 3, 2);
		send(CMD_LOAD, 3, 3);
		send(CMD_LOAD, 3, 2);
		send(CMD_LOAD, 1, 2);
		send(CMD_LOAD, 4, 5);
		send(CMD_LOAD, 5, 4);
		send(CMD_LOAD, 5, 6);
		send(CMD_RUN, 0, 0);
		for (int v = 0; v <= 8; v++) send(CMD_QUERY, v, 0);
		send(CMD_LOAD, 6, 5);
		send(CMD_QUERY, 6, 0);

		for (int p = 0; p < 5 && tracker.last_vtx < 900; p++)
			grow_graph($urandom_range(10, 45));

		// edges on the top vertex, then a run over the whole range
		write_limit(1024);
		repeat (20) send(CMD_LOAD, 1023, $urandom_range(0, 1023));
		send(CMD_LOAD, 1023, 0);
		send(CMD_LOAD, 1023, 1023);
		send(CMD_RUN, 0, 0);
		send(CMD_QUERY, 1023, 0);
		query_some(10);
		write_limit(37);
		send(CMD_RUN, 0, 0);
		query_some(10);

		drain();
		repeat (50) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+design
design/kcd_pkg.sv
design/kcore_decomposition_engine.sv
tb/sv/tb_kcore_decomposition_engine.sv
